[sv/v32tse_pkg.sv]
// ----------------------------------------------------------------------------
// V.32 trellis symbol encoder package
// Shared types, widths, register indexes and mapping tables.
// ----------------------------------------------------------------------------
package v32tse_pkg;

    localparam int DATA_W   = 16;
    localparam int MASKED_W = 6;
    localparam int POINT_W  = 7;
    localparam int MODE_W   = 8;
    localparam int COUNT_W  = 3;
    localparam int CFG_W    = 8;

    // Configuration register indexes.
    localparam logic CFG_UNCODED_COUNT = 1'b0;
    localparam logic CFG_MODE_TAG      = 1'b1;

    localparam logic [COUNT_W-1:0] MAX_UNCODED   = 3'd4;
    localparam logic [COUNT_W-1:0] RESET_UNCODED = 3'd2;

    typedef struct packed {
        logic [1:0] quadrant;
        logic [1:0] differential;
        logic [2:0] convolutional;
    } tse_state_t;

    typedef struct packed {
        logic [POINT_W-1:0]  signal_point;
        logic [MASKED_W-1:0] masked_input;
    } tse_result_t;

    // Differential table, indexed by {top bits, previous differential state}.
    localparam logic [1:0] DIFF_TAB [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd3, 2'd1, 2'd0,
        2'd3, 2'd2, 2'd0, 2'd1
    };

    // Convolutional next state, indexed by {state, new differential state}.
    localparam logic [2:0] NEXT_STATE_TAB [32] = '{
        3'd0, 3'd6, 3'd2, 3'd4,
        3'd2, 3'd4, 3'd0, 3'd6,
        3'd4, 3'd2, 3'd6, 3'd0,
        3'd6, 3'd0, 3'd4, 3'd2,
        3'd1, 3'd5, 3'd7, 3'd3,
        3'd3, 3'd7, 3'd5, 3'd1,
        3'd7, 3'd3, 3'd1, 3'd5,
        3'd5, 3'd1, 3'd3, 3'd7
    };

    // Rotation words: one nibble per quadrant, low three bits used.
    localparam logic [15:0] ROT_TAB [8] = '{
        16'h6170, 16'h7061, 16'h5342, 16'h4253,
        16'h2534, 16'h3425, 16'h1706, 16'h0617
    };

endpackage

[sv/v32_trellis_symbol_encoder.sv]
// ----------------------------------------------------------------------------
// V.32 trellis symbol encoder
// Maps one data word per symbol to a rotated, trellis-coded signal point.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid/s_ready) carries one data word per symbol, with
// a flag that marks the last word of a block. The result channel
// (m_valid/m_ready) returns exactly one transaction per input transaction,
// in order: the signal point, the mode tag, the masked input and the echoed
// last flag.
// An input transaction is held in an input register, mapped by short
// combinational logic, and captured in the output register, which raises
// m_valid; the result then leaves when m_ready is high. Throughput is one
// transaction per cycle while the receiver does not stall, set by the
// single mapping stage between the two registers.
// When the receiver stalls, the output register holds its transaction and
// the input register still takes one more; s_ready falls only when both
// are full. Encoder state advances once per transaction as it moves into
// the output register.
// Reset (aresetn low, synchronous) empties both registers and clears the quadrant,
// differential and convolutional state; uncoded_bit_count returns to 2 and mode_tag to 0.
// Configuration must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module v32_trellis_symbol_encoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [v32tse_pkg::CFG_W-1:0]     cfg_data,
    // Input channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [v32tse_pkg::DATA_W-1:0]    s_data_word,
    input  logic                             s_last_word,
    // Result channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [v32tse_pkg::POINT_W-1:0]   m_signal_point,
    output logic [v32tse_pkg::MODE_W-1:0]    m_symbol_mode,
    output logic [v32tse_pkg::MASKED_W-1:0]  m_masked_input,
    output logic                             m_last_symbol
);
    import v32tse_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0]  uncoded_count_reg;
    logic [MODE_W-1:0]   mode_tag_reg;

    // Input register. Only the low bits of the data word can survive the
    // mask, so the rest is dropped at capture.
    logic                s1_valid_reg;
    logic [MASKED_W-1:0] s1_data_reg;
    logic                s1_last_reg;

    // Encoder state, updated as each transaction leaves the input register.
    tse_state_t          state_reg;
    tse_state_t          state_next;
    tse_result_t         result;

    // Output register.
    logic                m_valid_reg;
    logic [POINT_W-1:0]  m_point_reg;
    logic [MODE_W-1:0]   m_mode_reg;
    logic [MASKED_W-1:0] m_masked_reg;
    logic                m_last_reg;

    logic                s1_advance;

    // The input register may move on whenever the output register is empty
    // or is being emptied in this cycle.
    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;

    v32tse_core u_core (
        .data_low      (s1_data_reg),
        .uncoded_count (uncoded_count_reg),
        .state_cur     (state_reg),
        .state_next    (state_next),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uncoded_count_reg <= RESET_UNCODED;
            mode_tag_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_UNCODED_COUNT: begin
                    // Counts above the maximum clamp to it.
                    uncoded_count_reg <= (cfg_data[COUNT_W-1:0] > MAX_UNCODED) ?
                                         MAX_UNCODED : cfg_data[COUNT_W-1:0];
                end
                CFG_MODE_TAG: begin
                    mode_tag_reg <= cfg_data[MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_advance) begin
                m_valid_reg <= s1_valid_reg;
                if (s1_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data_word[MASKED_W-1:0];
            s1_last_reg <= s_last_word;
        end
        if (s1_advance && s1_valid_reg) begin
            m_point_reg  <= result.signal_point;
            m_mode_reg   <= mode_tag_reg;
            m_masked_reg <= result.masked_input;
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_signal_point = m_point_reg;
    assign m_symbol_mode  = m_mode_reg;
    assign m_masked_input = m_masked_reg;
    assign m_last_symbol  = m_last_reg;

endmodule

[sv/v32tse_core.sv]
// ----------------------------------------------------------------------------
// V.32 trellis symbol mapper
// Combinational mapping of one data word to a signal point and next state.
// ----------------------------------------------------------------------------
module v32tse_core (
    input  logic [v32tse_pkg::MASKED_W-1:0] data_low,
    input  logic [v32tse_pkg::COUNT_W-1:0]  uncoded_count,
    input  v32tse_pkg::tse_state_t          state_cur,
    output v32tse_pkg::tse_state_t          state_next,
    output v32tse_pkg::tse_result_t         result
);
    import v32tse_pkg::*;

    logic [POINT_W-1:0]  keep_mask;
    logic [POINT_W-1:0]  uncoded_mask;
    logic [MASKED_W-1:0] masked;
    logic [MASKED_W-1:0] low_bits;
    logic [MASKED_W-1:0] shifted;
    logic [1:0]          top_bits;
    logic [2:0]          sel;
    logic [15:0]         rot_word;
    logic [2:0]          rot;

    always_comb begin
        keep_mask    = (7'd1 << (uncoded_count + 3'd2)) - 7'd1;
        uncoded_mask = (7'd1 << uncoded_count) - 7'd1;
        masked   = data_low & keep_mask[MASKED_W-1:0];
        low_bits = masked & uncoded_mask[MASKED_W-1:0];
        shifted  = masked >> uncoded_count;
        top_bits = shifted[1:0];

        state_next.differential  = DIFF_TAB[{top_bits, state_cur.differential}];
        // The redundant bit comes from the state before this symbol's update.
        sel                      = {state_cur.convolutional[2], state_next.differential};
        state_next.quadrant      = state_cur.quadrant - 2'd1;
        state_next.convolutional =
            NEXT_STATE_TAB[{state_cur.convolutional, state_next.differential}];

        rot_word = ROT_TAB[sel];
        rot      = rot_word[{state_next.quadrant, 2'b00} +: 3];

        result.signal_point = ({4'd0, rot} << uncoded_count) + {1'b0, low_bits};
        result.masked_input = masked;
    end

endmodule

[sv/v32tse_checker.sv]
// ----------------------------------------------------------------------------
// V.32 trellis symbol encoder checker
// Port-level assertions on flow control and latency, bound to the top level.
// ----------------------------------------------------------------------------
module v32tse_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_last_word,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [v32tse_pkg::POINT_W-1:0]   m_signal_point,
    input logic [v32tse_pkg::MODE_W-1:0]    m_symbol_mode,
    input logic [v32tse_pkg::MASKED_W-1:0]  m_masked_input,
    input logic                             m_last_symbol
);
    import v32tse_pkg::*;

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_signal_point) &&
        $stable(m_symbol_mode) && $stable(m_masked_input) && $stable(m_last_symbol))
        else $error("result transaction changed while stalled");

    // A receiver that is ready never blocks the input channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while receiver ready");

    // With the receiver ready, an accepted transaction reaches the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready |=> m_valid)
        else $error("result missing two cycles after acceptance");

    // The last flag travels with its transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_word ##1 m_ready |=> m_last_symbol)
        else $error("last flag lost");

endmodule

bind v32_trellis_symbol_encoder v32tse_checker u_v32tse_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_word    (s_last_word),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_signal_point (m_signal_point),
    .m_symbol_mode  (m_symbol_mode),
    .m_masked_input (m_masked_input),
    .m_last_symbol  (m_last_symbol)
);
